### rtl/smx_pkg.sv
// Package for the stack machine execute block: opcodes, flag selectors and
// the encodings of the stack cache. Used by rtl/stack_machine_execute.sv.
package smx_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam logic [15:0] PC_RESET = 16'h0002;
	localparam logic [15:0] PC_STEP = 16'd2;

	typedef enum logic [3:0] {
		FN_NOP      = 4'd0,
		FN_PUSH     = 4'd1,
		FN_DUP      = 4'd2,
		FN_DROP     = 4'd3,
		FN_CMP      = 4'd4,
		FN_ADD      = 4'd5,
		FN_ROTL     = 4'd6,
		FN_NAND     = 4'd7,
		FN_HOP_NE   = 4'd8,
		FN_HOP      = 4'd9,
		FN_LOADFLAG = 4'd10,
		FN_OUT      = 4'd11,
		FN_IN       = 4'd12,
		FN_HALT     = 4'd13,
		FN_NONE     = 4'd14
	} func_t;

	typedef enum logic [7:0] {
		FSEL_ZERO  = 8'd0,
		FSEL_CARRY = 8'd1,
		FSEL_EQUAL = 8'd2
	} flag_sel_t;

	// How the stack pointer moves for one instruction.
	typedef enum logic [1:0] {
		MV_NONE,
		MV_PUSH,
		MV_POP1,
		MV_POP2
	} move_t;

	// Where a cached stack entry currently lives.
	typedef enum logic [1:0] {
		SRC_REG,
		SRC_RDA,
		SRC_RDB
	} src_t;

	function automatic logic [7:0] rotl8(input logic [7:0] val, input logic [2:0] amt);
		logic [15:0] dbl;
		dbl = {val, val} << amt;
		return dbl[15:8];
	endfunction

endpackage

### rtl/stack_machine_execute.sv
// Execute stage of an 8-bit stack machine: one decoded instruction per request.
// Depends on rtl/smx_pkg.sv for opcodes, selectors and the rotate function.
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid/s_tready    s_tuser func, s_tdata operand, input char
//  m_*       out        m_tvalid/m_tready    m_tuser char_valid, m_tdata pc, char, flags
//  cfg_*     in         cfg_valid/cfg_ready  cfg_data io_enable
//
// A request is registered in an input stage and executed from there, one
// instruction per cycle while the result is not stalled; the limit is the loop
// from the machine state through the execute logic back into the state. The
// three top stack entries are cached in registers; the rest sits in a memory
// with two registered read ports. Reset clears the state at once: the memory
// has a valid bit per entry, so no clearing pass is needed. A stalled result
// holds the input stage, which then holds s_tready low.
module stack_machine_execute #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [3:0]  s_tuser,   // [3:0] func
	input  logic [15:0] s_tdata,   // [7:0] operand_byte, [15:8] input_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_tuser,   // [0] char_valid
	output logic [63:0] m_tdata,   // [15:0] next_pc, [23:16] char_out, [24] halted,
	                               // [32:25] top_value, [40:33] equal_out,
	                               // [48:41] zero_out, [56:49] carry_out, rest zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // io_enable
);
	import smx_pkg::*;

	localparam int PW = $clog2(STACK_DEPTH);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(STACK_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? PW'(STACK_DEPTH - 1) : p - PW'(1);
	endfunction

	// Input stage
	logic        valid_s1;
	logic [3:0]  func_s1;
	logic [7:0]  opnd_s1;
	logic [7:0]  ichr_s1;

	// Output register
	logic        out_valid_q;
	logic        out_user_q;
	logic [63:0] out_data_q;

	// Machine state
	logic          io_en_q;
	logic [15:0]   pc_q;
	logic [PW-1:0] ptr_q;
	logic [7:0]    eq_q;
	logic [7:0]    zero_q;
	logic [7:0]    carry_q;
	logic          halt_q;
	logic [7:0]    top_q;
	logic [7:0]    t1_q;
	logic [7:0]    t2_q;
	src_t          t1_src_q;
	src_t          t2_src_q;

	// Backing store
	logic [7:0]             mem [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] vld_q;
	logic [7:0]             rda_q;
	logic [7:0]             rdb_q;
	logic                   rda_vld_q;
	logic                   rdb_vld_q;

	logic          out_free;
	logic          fire;
	logic [7:0]    rda;
	logic [7:0]    rdb;
	logic [7:0]    t1_eff;
	logic [7:0]    t2_eff;
	logic [PW-1:0] p_inc;
	logic [PW-1:0] p_dec;
	logic [PW-1:0] p_dec2;
	logic [PW-1:0] rd_a_addr;
	logic [PW-1:0] rd_b_addr;
	logic [15:0]   pc_adv;
	logic [15:0]   hop_target;

	logic [15:0]   nx_pc;
	logic [PW-1:0] nx_ptr;
	logic [7:0]    nx_eq;
	logic [7:0]    nx_zero;
	logic [7:0]    nx_carry;
	logic          nx_halt;
	logic [7:0]    nx_top;
	move_t         mv;
	logic [7:0]    push_val;
	logic          pop_wr;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	logic          ch_vld;
	logic [7:0]    ch;

	assign out_free  = !out_valid_q || m_tready;
	assign fire      = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_user_q;
	assign m_tdata  = out_data_q;

	assign rda    = rda_vld_q ? rda_q : 8'h00;
	assign rdb    = rdb_vld_q ? rdb_q : 8'h00;
	assign t1_eff = (t1_src_q == SRC_RDA) ? rda : t1_q;

	always_comb begin
		case (t2_src_q)
			SRC_RDA: t2_eff = rda;
			SRC_RDB: t2_eff = rdb;
			default: t2_eff = t2_q;
		endcase
	end

	assign p_inc      = ptr_inc(ptr_q);
	assign p_dec      = ptr_dec(ptr_q);
	assign p_dec2     = ptr_dec(p_dec);
	assign rd_a_addr  = ptr_dec(p_dec2);
	assign rd_b_addr  = ptr_dec(rd_a_addr);
	assign pc_adv     = pc_q + PC_STEP;
	// Target is the second popped byte shifted left by four bits, ORed with the first popped byte.
	assign hop_target = {4'h0, t1_eff, 4'h0} | {8'h00, top_q};

	always_comb begin
		nx_pc    = pc_q;
		nx_eq    = eq_q;
		nx_zero  = zero_q;
		nx_carry = carry_q;
		nx_halt  = halt_q;
		mv       = MV_NONE;
		push_val = top_q;
		pop_wr   = 1'b0;
		ch_vld   = 1'b0;
		ch       = 8'h00;
		if (!halt_q) begin
			unique case (func_t'(func_s1))
				FN_NOP: begin
					nx_pc = pc_adv;
				end
				FN_PUSH: begin
					mv       = MV_PUSH;
					push_val = opnd_s1;
					nx_pc    = pc_adv;
				end
				FN_DUP: begin
					mv    = MV_PUSH;
					nx_pc = pc_adv;
				end
				FN_DROP: begin
					mv       = MV_POP1;
					push_val = t1_eff;
					nx_pc    = pc_adv;
				end
				FN_CMP: begin
					mv      = MV_POP2;
					nx_eq   = {7'h00, top_q == t1_eff};
					nx_zero = {7'h00, (top_q == 8'h00) && (t1_eff == 8'h00)};
					nx_pc   = pc_adv;
				end
				FN_ADD: begin
					mv       = MV_POP1;
					pop_wr   = 1'b1;
					push_val = top_q + t1_eff + carry_q;
					nx_pc    = pc_adv;
				end
				FN_ROTL: begin
					mv       = MV_POP1;
					pop_wr   = 1'b1;
					push_val = rotl8(top_q, t1_eff[2:0]);
					nx_pc    = pc_adv;
				end
				FN_NAND: begin
					mv       = MV_POP1;
					pop_wr   = 1'b1;
					push_val = ~(top_q & t1_eff);
					nx_pc    = pc_adv;
				end
				FN_HOP_NE: begin
					mv    = MV_POP2;
					nx_pc = (eq_q == 8'h00) ? hop_target : pc_adv;
				end
				FN_HOP: begin
					mv    = MV_POP2;
					nx_pc = hop_target;
				end
				FN_LOADFLAG: begin
					mv    = MV_POP2;
					nx_pc = pc_adv;
					case (flag_sel_t'(opnd_s1))
						FSEL_ZERO:  nx_zero  = top_q;
						FSEL_CARRY: nx_carry = top_q;
						FSEL_EQUAL: nx_eq    = top_q;
						default:    ;
					endcase
				end
				FN_OUT: begin
					nx_pc = pc_adv;
					if (io_en_q) begin
						mv     = MV_POP2;
						ch_vld = 1'b1;
						ch     = top_q;
					end
				end
				FN_IN: begin
					nx_pc = pc_adv;
					if (io_en_q) begin
						mv       = MV_PUSH;
						push_val = ichr_s1;
					end
				end
				FN_HALT: begin
					nx_halt = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Pointer, memory write and new top of stack follow from the pointer move.
	always_comb begin
		nx_ptr  = ptr_q;
		wr_en   = 1'b0;
		wr_addr = p_inc;
		nx_top  = top_q;
		unique case (mv)
			MV_PUSH: begin
				nx_ptr = p_inc;
				wr_en  = 1'b1;
				nx_top = push_val;
			end
			MV_POP1: begin
				nx_ptr  = p_dec;
				wr_en   = pop_wr;
				wr_addr = p_dec;
				nx_top  = push_val;
			end
			MV_POP2: begin
				nx_ptr = p_dec2;
				nx_top = t2_eff;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			opnd_s1 <= s_tdata[7:0];
			ichr_s1 <= s_tdata[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_user_q <= ch_vld;
			out_data_q <= {7'h00, nx_carry, nx_zero, nx_eq, nx_top, nx_halt, ch, nx_pc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			io_en_q <= 1'b0;
		end else if (cfg_valid) begin
			io_en_q <= cfg_data;
		end
	end

	// The top three entries stay in registers; entries that come back into
	// view after pops are read from the memory and picked up from the registered read ports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= PC_RESET;
			ptr_q    <= '0;
			eq_q     <= 8'h00;
			zero_q   <= 8'h00;
			carry_q  <= 8'h00;
			halt_q   <= 1'b0;
			top_q    <= 8'h00;
			t1_q     <= 8'h00;
			t2_q     <= 8'h00;
			t1_src_q <= SRC_REG;
			t2_src_q <= SRC_REG;
			vld_q    <= '0;
		end else if (fire) begin
			pc_q    <= nx_pc;
			ptr_q   <= nx_ptr;
			eq_q    <= nx_eq;
			zero_q  <= nx_zero;
			carry_q <= nx_carry;
			halt_q  <= nx_halt;
			top_q   <= nx_top;
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			unique case (mv)
				MV_PUSH: begin
					t1_q     <= top_q;
					t2_q     <= t1_eff;
					t1_src_q <= SRC_REG;
					t2_src_q <= SRC_REG;
				end
				MV_POP1: begin
					t1_q     <= t2_eff;
					t1_src_q <= SRC_REG;
					t2_src_q <= SRC_RDA;
				end
				MV_POP2: begin
					t1_src_q <= SRC_RDA;
					t2_src_q <= SRC_RDB;
				end
				default: begin
					t1_q     <= t1_eff;
					t2_q     <= t2_eff;
					t1_src_q <= SRC_REG;
					t2_src_q <= SRC_REG;
				end
			endcase
		end
	end

	// Reads go three and four entries below the current top; a write in the
	// same cycle never lands on an entry whose read data is used.
	always_ff @(posedge clk) begin
		if (fire) begin
			if (wr_en) begin
				mem[wr_addr] <= push_val;
			end
			rda_q     <= mem[rd_a_addr];
			rdb_q     <= mem[rd_b_addr];
			rda_vld_q <= vld_q[rd_a_addr];
			rdb_vld_q <= vld_q[rd_b_addr];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) halt_q |=> halt_q)
		else $error("halt bit cleared after being set");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && halt_q |=> (pc_q == $past(pc_q)) && (ptr_q == $past(ptr_q)))
		else $error("machine state changed while halted");

	assert property (@(posedge clk) disable iff (!arst_n) ptr_q <= PW'(STACK_DEPTH - 1))
		else $error("stack pointer out of range");

endmodule
